// ----- hw/rtl/lmvs_pkg.sv -----
// Package for the longest mountain or valley subsequence block.
// Holds sizes, the controller state type and the command and status structs.
// No dependencies.
package lmvs_pkg;

  localparam int unsigned MaxItems = 1024;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned ValW     = 32;
  localparam int unsigned LenW     = 11;
  localparam logic [LenW-1:0] LenMax = '1;

  typedef enum logic [2:0] {
    StIdle,
    StSrchRd,
    StSrchCmp,
    StPlace,
    StBackInit,
    StBackRd,
    StBackLoad,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic srch_read;
    logic srch_step;
    logic place;
    logic back;
    logic back_init;
    logic back_read;
    logic back_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic search_done;
    logic k_last;
    logic out_busy;
  } status_t;

endpackage

// ----- hw/rtl/longest_mountain_or_valley_subsequence.sv -----
// Each item is searched for in the two tails memories side by side, one registered
// read and one compare per step, and is then placed. A last item adds a setup step
// and a backward pass over the stored elements, each one read, loaded, searched
// and placed in turn; then the result is loaded once the output register is free.
// One item at a time; reset (rst_ni, async low) clears all counts and out_valid_o.
module longest_mountain_or_valley_subsequence (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [lmvs_pkg::ValW-1:0] value_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lmvs_pkg::LenW-1:0]       best_length_o,
  output logic                            overflow_o
);

  lmvs_pkg::cmd_t    cmd;
  lmvs_pkg::status_t sts;

  lmvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lmvs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .last_i        (last_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .best_length_o (best_length_o),
    .overflow_o    (overflow_o)
  );

endmodule

// ----- hw/rtl/lmvs_ctrl.sv -----
// Controller state machine for the mountain or valley search.
// Depends on lmvs_pkg; drives lmvs_dp through command and status structs.
module lmvs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_i,
  output logic             in_ready_o,
  input  lmvs_pkg::status_t sts_i,
  output lmvs_pkg::cmd_t   cmd_o
);

  lmvs_pkg::state_e state_q, state_d;
  logic back_q, back_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmvs_pkg::StIdle;
      back_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      back_q  <= back_d;
    end
  end

  always_comb begin
    state_d = state_q;
    back_d  = back_q;
    unique case (state_q)
      lmvs_pkg::StIdle: begin
        if (in_valid_i) begin
          if (!sts_i.full) state_d = lmvs_pkg::StSrchRd;
          else if (last_i) state_d = lmvs_pkg::StBackInit;
        end
      end
      lmvs_pkg::StSrchRd: begin
        if (sts_i.search_done) state_d = lmvs_pkg::StPlace;
        else state_d = lmvs_pkg::StSrchCmp;
      end
      lmvs_pkg::StSrchCmp: state_d = lmvs_pkg::StSrchRd;
      lmvs_pkg::StPlace: begin
        if (!back_q) begin
          state_d = sts_i.last ? lmvs_pkg::StBackInit : lmvs_pkg::StIdle;
        end else begin
          state_d = sts_i.k_last ? lmvs_pkg::StDone : lmvs_pkg::StBackRd;
        end
      end
      lmvs_pkg::StBackInit: begin
        state_d = lmvs_pkg::StBackRd;
        back_d  = 1'b1;
      end
      lmvs_pkg::StBackRd:   state_d = lmvs_pkg::StBackLoad;
      lmvs_pkg::StBackLoad: state_d = lmvs_pkg::StSrchRd;
      lmvs_pkg::StDone: begin
        if (!sts_i.out_busy) begin
          state_d = lmvs_pkg::StIdle;
          back_d  = 1'b0;
        end
      end
      default: state_d = lmvs_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.back = back_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      lmvs_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lmvs_pkg::StSrchRd:   cmd_o.srch_read = !sts_i.search_done;
      lmvs_pkg::StSrchCmp:  cmd_o.srch_step = 1'b1;
      lmvs_pkg::StPlace:    cmd_o.place = 1'b1;
      lmvs_pkg::StBackInit: cmd_o.back_init = 1'b1;
      lmvs_pkg::StBackRd:   cmd_o.back_read = 1'b1;
      lmvs_pkg::StBackLoad: cmd_o.back_load = 1'b1;
      lmvs_pkg::StDone:     cmd_o.emit = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/lmvs_dp.sv -----
// Datapath: element and length stores, rising and falling tails memories,
// binary search registers and output register. Depends on lmvs_pkg.
module lmvs_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [lmvs_pkg::ValW-1:0] value_i,
  input  logic                         last_i,
  input  lmvs_pkg::cmd_t               cmd_i,
  output lmvs_pkg::status_t            sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lmvs_pkg::LenW-1:0]    best_length_o,
  output logic                         overflow_o
);

  localparam int unsigned IW = lmvs_pkg::IdxW;
  localparam int unsigned CW = lmvs_pkg::CntW;
  localparam int unsigned VW = lmvs_pkg::ValW;
  localparam int unsigned LW = lmvs_pkg::LenW;
  localparam logic [CW-1:0] MaxCnt = CW'(lmvs_pkg::MaxItems);
  localparam logic [CW-1:0] LastIdx = CW'(lmvs_pkg::MaxItems - 1);

  logic signed [VW-1:0] value_mem [lmvs_pkg::MaxItems];
  logic [LW-1:0]        rlen_mem  [lmvs_pkg::MaxItems];
  logic [LW-1:0]        flen_mem  [lmvs_pkg::MaxItems];
  logic signed [VW-1:0] rtail_mem [lmvs_pkg::MaxItems];
  logic signed [VW-1:0] ftail_mem [lmvs_pkg::MaxItems];

  logic [CW-1:0] rcnt_q, fcnt_q, icnt_q, k_q;
  logic [LW-1:0] best_q;
  logic          drop_q, last_q;
  logic signed [VW-1:0] v_q, vrd_q, rrd_q, frd_q;
  logic [LW-1:0] rl_rd_q, fl_rd_q;
  logic [CW-1:0] rlo_q, rhi_q, flo_q, fhi_q;
  logic          out_valid_q, out_over_q;
  logic [LW-1:0] out_best_q;

  logic [CW:0]   rsum, fsum;
  logic [CW-1:0] rmid, fmid, rpos, fpos, k_m1;
  logic          ract, fact;
  logic [LW-1:0] rlen, flen;
  logic [LW:0]   mount, valley, best_w;

  assign rsum = {1'b0, rlo_q} + {1'b0, rhi_q};
  assign fsum = {1'b0, flo_q} + {1'b0, fhi_q};
  assign rmid = rsum[CW:1];
  assign fmid = fsum[CW:1];
  assign ract = rlo_q < rhi_q;
  assign fact = flo_q < fhi_q;
  assign rpos = (rlo_q > LastIdx) ? LastIdx : rlo_q;
  assign fpos = (flo_q > LastIdx) ? LastIdx : flo_q;
  assign rlen = LW'(rpos) + LW'(1);
  assign flen = LW'(fpos) + LW'(1);
  assign k_m1 = k_q - CW'(1);
  assign mount  = {1'b0, rl_rd_q} + {1'b0, rlen} - (LW+1)'(1);
  assign valley = {1'b0, fl_rd_q} + {1'b0, flen} - (LW+1)'(1);

  always_comb begin
    best_w = {1'b0, best_q};
    if (mount > best_w) best_w = mount;
    if (valley > best_w) best_w = valley;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && icnt_q < MaxCnt) value_mem[icnt_q[IW-1:0]] <= value_i;
    if (cmd_i.place && !cmd_i.back) begin
      rlen_mem[icnt_q[IW-1:0]] <= rlen;
      flen_mem[icnt_q[IW-1:0]] <= flen;
    end
    if (cmd_i.back_read) begin
      vrd_q   <= value_mem[k_m1[IW-1:0]];
      rl_rd_q <= rlen_mem[k_m1[IW-1:0]];
      fl_rd_q <= flen_mem[k_m1[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_read) begin
      rrd_q <= rtail_mem[rmid[IW-1:0]];
      frd_q <= ftail_mem[fmid[IW-1:0]];
    end
    if (cmd_i.place) begin
      rtail_mem[rpos[IW-1:0]] <= v_q;
      ftail_mem[fpos[IW-1:0]] <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) v_q <= value_i;
    else if (cmd_i.back_load) v_q <= vrd_q;
    if (cmd_i.load || cmd_i.back_load) begin
      rlo_q <= '0;
      flo_q <= '0;
      rhi_q <= rcnt_q;
      fhi_q <= fcnt_q;
    end else if (cmd_i.srch_step) begin
      if (ract) begin
        if (rrd_q < v_q) rlo_q <= rmid + CW'(1);
        else rhi_q <= rmid;
      end
      if (fact) begin
        if (frd_q > v_q) flo_q <= fmid + CW'(1);
        else fhi_q <= fmid;
      end
    end
    if (cmd_i.emit) out_best_q <= best_q;
    if (cmd_i.emit) out_over_q <= drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q      <= '0;
      fcnt_q      <= '0;
      icnt_q      <= '0;
      k_q         <= '0;
      best_q      <= '0;
      drop_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        last_q <= last_i;
        if (icnt_q >= MaxCnt) drop_q <= 1'b1;
      end
      if (cmd_i.place) begin
        if (rlo_q == rcnt_q) rcnt_q <= rcnt_q + CW'(1);
        if (flo_q == fcnt_q) fcnt_q <= fcnt_q + CW'(1);
        if (!cmd_i.back) icnt_q <= icnt_q + CW'(1);
        else begin
          k_q    <= k_m1;
          best_q <= best_w[LW] ? lmvs_pkg::LenMax : best_w[LW-1:0];
        end
      end
      if (cmd_i.back_init) begin
        rcnt_q <= '0;
        fcnt_q <= '0;
        best_q <= '0;
        k_q    <= icnt_q;
      end
      if (cmd_i.emit) begin
        rcnt_q <= '0;
        fcnt_q <= '0;
        icnt_q <= '0;
        best_q <= '0;
        drop_q <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.full        = icnt_q >= MaxCnt;
  assign sts_o.last        = last_q;
  assign sts_o.search_done = !ract && !fact;
  assign sts_o.k_last      = k_q == CW'(1);
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign best_length_o = out_best_q;
  assign overflow_o    = out_over_q;

endmodule
